// ----- rtl/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions of the complex arithmetic unit
// Widths, operation, status and kind codes, transaction structs and the
// saturation helper used by the back end.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = DATA_WIDTH + 1;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int REM_W      = PROD_W + 1;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int CMP_W      = NUM_W + DATA_WIDTH;

    localparam logic [REM_W-1:0] ROUND_HALF =
        (FRAC_BITS > 0) ? (REM_W'(1) << (FRAC_BITS - 1)) : '0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // work kinds handed from the front end to the back end
    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_ROUND = 2'd1;
    localparam logic [1:0] KIND_DIV   = 2'd2;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] re;
        logic [DATA_WIDTH-1:0] im;
        logic [1:0]            status;
    } result_t;

    typedef struct packed {
        logic [1:0]        kind;
        result_t           res;
        logic              neg_re;
        logic [PROD_W-1:0] mag_re;
        logic              neg_im;
        logic [PROD_W-1:0] mag_im;
        logic [PROD_W-1:0] den;
    } token_t;

    typedef struct packed {
        logic [1:0]            kind;
        result_t               res;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [REM_W-1:0]      rem_re;
        logic [REM_W-1:0]      rem_im;
        logic [DATA_WIDTH-1:0] low_re;
        logic [DATA_WIDTH-1:0] low_im;
        logic [PROD_W-1:0]     den;
    } stage_t;

    typedef struct packed {
        logic                  ovf;
        logic [DATA_WIDTH-1:0] val;
    } sat_t;

    // Clamp a sign-magnitude part to the signed data range.
    function automatic sat_t sat_part(input logic neg, input logic [REM_W-1:0] mag,
                                      input logic ovf_in);
        logic [REM_W-1:0] lim;
        sat_t             r;
        lim = neg ? (REM_W'(1) << (DATA_WIDTH - 1))
                  : ((REM_W'(1) << (DATA_WIDTH - 1)) - REM_W'(1));
        if (ovf_in || (mag > lim))
        begin
            r.ovf = 1'b1;
            r.val = neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = neg ? (~mag[DATA_WIDTH-1:0] + 1'b1) : mag[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/cau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: operand intake and classification
// Three stages: partial products and sums, combination and saturation of
// add/subtract, then sign-magnitude split. Emits one token per transaction.
// ----------------------------------------------------------------------------
module cau_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [1:0]                             opcode,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_imag,
    output logic                                   tok_push,
    output cau_pkg::token_t                        tok,
    input  logic                                   tok_full
);

    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PROD_W;
    localparam int RW = cau_pkg::REM_W;
    localparam int SW = cau_pkg::SUM_W;

    logic en;

    // stage 1
    logic                 v1_reg;
    logic [1:0]           op1_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, qr_reg, qi_reg;
    logic signed [PW-1:0] prr_next, pii_next, pri_next, pir_next, qr_next, qi_next;
    logic signed [SW-1:0] sre_reg, sim_reg, sre_next, sim_next;
    logic                 bz1_reg, bz1_next;

    // stage 2
    logic                 v2_reg;
    logic [1:0]           kind2_reg, kind2_next;
    cau_pkg::result_t     res2_reg, res2_next;
    logic signed [RW-1:0] x2_reg, y2_reg, x2_next, y2_next;
    logic [PW-1:0]        den2_reg, den2_next;
    logic                 ovf_re, ovf_im;
    logic [DW-1:0]        sat_re, sat_im;

    // stage 3
    logic                 v3_reg;
    cau_pkg::token_t      tok3_reg, tok3_next;
    logic [RW-1:0]        abs_re, abs_im;

    // advance unless the last stage holds a token the queue cannot take
    assign en       = !(v3_reg && tok_full);
    assign full     = !en;
    assign tok_push = en && v3_reg;
    assign tok      = tok3_reg;

    // products, sums and differences
    assign prr_next = a_real * b_real;
    assign pii_next = a_imag * b_imag;
    assign pri_next = a_real * b_imag;
    assign pir_next = a_imag * b_real;
    assign qr_next  = b_real * b_real;
    assign qi_next  = b_imag * b_imag;
    assign sre_next = (opcode == cau_pkg::OP_SUB) ? (SW'(a_real) - SW'(b_real))
                                                  : (SW'(a_real) + SW'(b_real));
    assign sim_next = (opcode == cau_pkg::OP_SUB) ? (SW'(a_imag) - SW'(b_imag))
                                                  : (SW'(a_imag) + SW'(b_imag));
    assign bz1_next = (b_real == '0) && (b_imag == '0);

    // saturate add/subtract results
    assign ovf_re = sre_reg[SW-1] != sre_reg[SW-2];
    assign ovf_im = sim_reg[SW-1] != sim_reg[SW-2];
    assign sat_re = ovf_re ? {sre_reg[SW-1], {(DW-1){!sre_reg[SW-1]}}} : sre_reg[DW-1:0];
    assign sat_im = ovf_im ? {sim_reg[SW-1], {(DW-1){!sim_reg[SW-1]}}} : sim_reg[DW-1:0];

    // combine products and classify
    always_comb
    begin
        kind2_next = cau_pkg::KIND_DONE;
        res2_next  = '0;
        x2_next    = RW'(prr_reg) - RW'(pii_reg);
        y2_next    = RW'(pri_reg) + RW'(pir_reg);
        den2_next  = PW'($unsigned(qr_reg) + $unsigned(qi_reg));
        unique case (op1_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                res2_next.re     = sat_re;
                res2_next.im     = sat_im;
                res2_next.status = (ovf_re || ovf_im) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            end
            cau_pkg::OP_MUL:
            begin
                kind2_next = cau_pkg::KIND_ROUND;
            end
            default:
            begin
                x2_next = RW'(prr_reg) + RW'(pii_reg);
                y2_next = RW'(pir_reg) - RW'(pri_reg);
                if (bz1_reg)
                begin
                    res2_next.status = cau_pkg::ST_DIVZ;
                end
                else
                begin
                    kind2_next = cau_pkg::KIND_DIV;
                end
            end
        endcase
    end

    // split into sign and magnitude
    assign abs_re = x2_reg[RW-1] ? (~x2_reg + 1'b1) : x2_reg;
    assign abs_im = y2_reg[RW-1] ? (~y2_reg + 1'b1) : y2_reg;

    always_comb
    begin
        tok3_next.kind   = kind2_reg;
        tok3_next.res    = res2_reg;
        tok3_next.neg_re = x2_reg[RW-1];
        tok3_next.mag_re = abs_re[PW-1:0];
        tok3_next.neg_im = y2_reg[RW-1];
        tok3_next.mag_im = abs_im[PW-1:0];
        tok3_next.den    = den2_reg;
    end

    // hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= opcode;
            prr_reg   <= prr_next;
            pii_reg   <= pii_next;
            pri_reg   <= pri_next;
            pir_reg   <= pir_next;
            qr_reg    <= qr_next;
            qi_reg    <= qi_next;
            sre_reg   <= sre_next;
            sim_reg   <= sim_next;
            bz1_reg   <= bz1_next;
            kind2_reg <= kind2_next;
            res2_reg  <= res2_next;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            den2_reg  <= den2_next;
            tok3_reg  <= tok3_next;
        end
    end

endmodule

// ----- rtl/cau_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue: token queue between front end and back end
// Small first-in first-out buffer so that either side can stall alone.
// ----------------------------------------------------------------------------
module cau_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cau_pkg::token_t wdata,
    output logic            full,
    input  logic            pop,
    output cau_pkg::token_t rdata,
    output logic            empty
);

    localparam int PTR_W = cau_pkg::QUEUE_PTR_W;

    cau_pkg::token_t  mem_reg [cau_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign full    = count_reg == (PTR_W+1)'(cau_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // store incoming token
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/cau_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back: rounding, restoring division and result buffering
// One setup stage, one quotient bit per stage for both parts, a final
// rounding and saturation step, and a two-entry result buffer.
// ----------------------------------------------------------------------------
module cau_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cau_pkg::token_t                        tok,
    input  logic                                   tok_empty,
    output logic                                   tok_pop,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]  result_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]  result_imag,
    output logic [1:0]                             status,
    output logic                                   empty,
    input  logic                                   pop
);

    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PROD_W;
    localparam int RW = cau_pkg::REM_W;
    localparam int NW = cau_pkg::NUM_W;
    localparam int CW = cau_pkg::CMP_W;

    logic             en;
    logic             vld_reg [0:DW];
    cau_pkg::stage_t  stg_reg [0:DW];
    cau_pkg::stage_t  stg_next [0:DW];
    logic [NW-1:0]    num_re, num_im;
    logic [CW-1:0]    den_cmp;

    cau_pkg::stage_t  fin;
    logic             rnd_re, rnd_im;
    logic [RW-1:0]    qm_re, qm_im;
    cau_pkg::sat_t    sat_re, sat_im;
    cau_pkg::result_t fin_res;

    cau_pkg::result_t obuf_reg [2];
    logic             ow_ptr_reg, or_ptr_reg;
    logic [1:0]       ocount_reg;
    logic             obuf_full, obuf_push, obuf_pop;

    // advance unless the last stage holds a result the buffer cannot take
    assign obuf_full = ocount_reg == 2'd2;
    assign en        = !(vld_reg[DW] && obuf_full);
    assign tok_pop   = en && !tok_empty;

    // set up rounding or division from the queue head
    assign num_re  = NW'(tok.mag_re) << cau_pkg::FRAC_BITS;
    assign num_im  = NW'(tok.mag_im) << cau_pkg::FRAC_BITS;
    assign den_cmp = CW'(tok.den) << DW;

    always_comb
    begin
        stg_next[0].kind   = tok.kind;
        stg_next[0].res    = tok.res;
        stg_next[0].neg_re = tok.neg_re;
        stg_next[0].neg_im = tok.neg_im;
        stg_next[0].den    = tok.den;
        stg_next[0].ovf_re = 1'b0;
        stg_next[0].ovf_im = 1'b0;
        stg_next[0].low_re = '0;
        stg_next[0].low_im = '0;
        stg_next[0].rem_re = (RW'(tok.mag_re) + cau_pkg::ROUND_HALF) >> cau_pkg::FRAC_BITS;
        stg_next[0].rem_im = (RW'(tok.mag_im) + cau_pkg::ROUND_HALF) >> cau_pkg::FRAC_BITS;
        if (tok.kind == cau_pkg::KIND_DIV)
        begin
            stg_next[0].ovf_re = CW'(num_re) >= den_cmp;
            stg_next[0].ovf_im = CW'(num_im) >= den_cmp;
            stg_next[0].rem_re = RW'(num_re >> DW);
            stg_next[0].rem_im = RW'(num_im >> DW);
            stg_next[0].low_re = num_re[DW-1:0];
            stg_next[0].low_im = num_im[DW-1:0];
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= DW; i++)
    begin : g_step
        logic [RW-1:0] t_re, t_im;
        logic          ge_re, ge_im;

        assign t_re  = {stg_reg[i-1].rem_re[RW-2:0], stg_reg[i-1].low_re[DW-1]};
        assign t_im  = {stg_reg[i-1].rem_im[RW-2:0], stg_reg[i-1].low_im[DW-1]};
        assign ge_re = t_re >= RW'(stg_reg[i-1].den);
        assign ge_im = t_im >= RW'(stg_reg[i-1].den);

        always_comb
        begin
            stg_next[i] = stg_reg[i-1];
            if (stg_reg[i-1].kind == cau_pkg::KIND_DIV)
            begin
                stg_next[i].rem_re = ge_re ? (t_re - RW'(stg_reg[i-1].den)) : t_re;
                stg_next[i].rem_im = ge_im ? (t_im - RW'(stg_reg[i-1].den)) : t_im;
                stg_next[i].low_re = {stg_reg[i-1].low_re[DW-2:0], ge_re};
                stg_next[i].low_im = {stg_reg[i-1].low_im[DW-2:0], ge_im};
            end
        end
    end

    // round the quotient, then saturate
    assign fin    = stg_reg[DW];
    assign rnd_re = {fin.rem_re, 1'b0} >= (RW+1)'(fin.den);
    assign rnd_im = {fin.rem_im, 1'b0} >= (RW+1)'(fin.den);
    assign qm_re  = RW'(fin.low_re) + RW'(rnd_re);
    assign qm_im  = RW'(fin.low_im) + RW'(rnd_im);

    always_comb
    begin
        sat_re = cau_pkg::sat_part(fin.neg_re, fin.rem_re, 1'b0);
        sat_im = cau_pkg::sat_part(fin.neg_im, fin.rem_im, 1'b0);
        if (fin.kind == cau_pkg::KIND_DIV)
        begin
            sat_re = cau_pkg::sat_part(fin.neg_re, qm_re, fin.ovf_re);
            sat_im = cau_pkg::sat_part(fin.neg_im, qm_im, fin.ovf_im);
        end
        fin_res = fin.res;
        if (fin.kind != cau_pkg::KIND_DONE)
        begin
            fin_res.re     = sat_re.val;
            fin_res.im     = sat_im.val;
            fin_res.status = (sat_re.ovf || sat_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        end
    end

    // hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DW; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !tok_empty;
            for (int k = 1; k <= DW; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // advance stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DW; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // result buffer
    assign obuf_push   = en && vld_reg[DW];
    assign obuf_pop    = pop && !empty;
    assign empty       = ocount_reg == 2'd0;
    assign result_real = obuf_reg[or_ptr_reg].re;
    assign result_imag = obuf_reg[or_ptr_reg].im;
    assign status      = obuf_reg[or_ptr_reg].status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ow_ptr_reg <= 1'b0;
            or_ptr_reg <= 1'b0;
            ocount_reg <= 2'd0;
        end
        else
        begin
            if (obuf_push)
            begin
                ow_ptr_reg <= !ow_ptr_reg;
            end
            if (obuf_pop)
            begin
                or_ptr_reg <= !or_ptr_reg;
            end
            if (obuf_push && !obuf_pop)
            begin
                ocount_reg <= ocount_reg + 2'd1;
            end
            else if (obuf_pop && !obuf_push)
            begin
                ocount_reg <= ocount_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (obuf_push)
        begin
            obuf_reg[ow_ptr_reg] <= fin_res;
        end
    end

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: Q16.16 complex add, subtract, multiply, divide
// Top level joining front end, token queue and back end.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while full is low and returns
// results in order. Every operation flows through the same pipeline of 3
// front stages, the token queue, 1 setup stage plus DATA_WIDTH
// restoring-division stages (one quotient bit each) and the result buffer.
// Throughput is one transaction per cycle while pop keeps up; the queue
// and the result buffer let the two sides stall independently.
// Products and quotients round to nearest with ties away from zero; results
// out of range saturate with overflow status; a zero divisor gives zero and
// divide-by-zero status.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [1:0]                             opcode,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  a_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0]  b_imag,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]  result_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0]  result_imag,
    output logic [1:0]                             status
);

    logic            tok_push, tok_full, tok_pop, tok_empty;
    cau_pkg::token_t tok_in, tok_out;

    cau_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .opcode   (opcode),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .tok_push (tok_push),
        .tok      (tok_in),
        .tok_full (tok_full)
    );

    cau_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .wdata (tok_in),
        .full  (tok_full),
        .pop   (tok_pop),
        .rdata (tok_out),
        .empty (tok_empty)
    );

    cau_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok         (tok_out),
        .tok_empty   (tok_empty),
        .tok_pop     (tok_pop),
        .result_real (result_real),
        .result_imag (result_imag),
        .status      (status),
        .empty       (empty),
        .pop         (pop)
    );

    // a divide-by-zero transaction always carries a zero result
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == cau_pkg::ST_DIVZ) |-> (result_real == '0 && result_imag == '0))
        else $error("divide-by-zero result not zero");

    // the unused status code never reaches the result ports
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == cau_pkg::ST_OK || status == cau_pkg::ST_DIVZ ||
                    status == cau_pkg::ST_OVF))
        else $error("invalid status on result");

    // the queue never accepts a token while full
    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        tok_full |-> !tok_push)
        else $error("token pushed into full queue");

endmodule
